// ----- hw/rtl/kpvf_pkg.sv -----
// kpvf_pkg: widths, register indexes, reset values and saturation helpers
// for the position/velocity kalman filter. No dependencies.
`timescale 1ns / 1ps
package kpvf_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int DT_W    = 21;
    localparam int NOISE_W = 31;
    localparam int CFG_IDX_W = 3;

    localparam int OP_W   = DATA_W + 1;
    localparam int PROD_W = 2 * OP_W;
    localparam int SUM_W  = DATA_W + 3;
    localparam int DVD_W  = DATA_W + FRAC_W;
    localparam int DCNT_W = $clog2(DVD_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_POS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SPEED = 3'd4;

    localparam logic [DT_W-1:0]    RST_TIME_STEP  = DT_W'(655);
    localparam logic [NOISE_W-1:0] RST_PROC_NOISE = NOISE_W'(66);
    localparam logic [NOISE_W-1:0] RST_MEAS_NOISE = NOISE_W'(6554);

    localparam logic signed [DATA_W-1:0] VAL_ONE = DATA_W'(1) << FRAC_W;
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // clamp a wide sum to the data range
    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (&v[SUM_W-1:DATA_W-1] || ~|v[SUM_W-1:DATA_W-1]) begin
            res = v[DATA_W-1:0];
        end else if (v[SUM_W-1]) begin
            res = VAL_MIN;
        end else begin
            res = VAL_MAX;
        end
        return res;
    endfunction

    // floor shift of a raw product, then clamp
    function automatic logic signed [DATA_W-1:0] sat_prod(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] sh;
        logic signed [DATA_W-1:0] res;
        sh = p >>> FRAC_W;
        if (&sh[PROD_W-1:DATA_W-1] || ~|sh[PROD_W-1:DATA_W-1]) begin
            res = sh[DATA_W-1:0];
        end else if (sh[PROD_W-1]) begin
            res = VAL_MIN;
        end else begin
            res = VAL_MAX;
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/kpvf_if.sv -----
// kpvf_in_if and kpvf_out_if: valid/ready channels of the kalman filter.
// Depends on kpvf_pkg for the data width.
`timescale 1ns / 1ps
interface kpvf_in_if import kpvf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] acceleration;
    logic signed [DATA_W-1:0] measured_position;
    modport source (output valid, output acceleration, output measured_position, input ready);
    modport sink   (input valid, input acceleration, input measured_position, output ready);
endinterface

interface kpvf_out_if import kpvf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] est_position;
    logic signed [DATA_W-1:0] est_speed;
    modport source (output valid, output est_position, output est_speed, input ready);
    modport sink   (input valid, input est_position, input est_speed, output ready);
endinterface

// ----- hw/rtl/kpvf_div.sv -----
// kpvf_div: fixed point signed divider, (num << FRAC_W) / den, truncated
// toward zero and clamped; one quotient bit per cycle. Uses kpvf_pkg.
`timescale 1ns / 1ps
module kpvf_div import kpvf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_num,
    input  logic signed [DATA_W-1:0] i_den,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_quo
);

    logic              r_busy;
    logic [DCNT_W-1:0] r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DVD_W-1:0]  r_dvd;
    logic [DATA_W-1:0] r_den;
    logic              r_neg;
    logic              r_dz;
    logic              r_nneg;
    logic              r_nzero;

    logic [DATA_W-1:0] num_mag;
    logic [DATA_W-1:0] den_mag;
    logic [DATA_W:0]   shifted;
    logic [DATA_W+1:0] diff;
    logic              ge;

    assign num_mag = i_num[DATA_W-1] ? DATA_W'(-i_num) : DATA_W'(i_num);
    assign den_mag = i_den[DATA_W-1] ? DATA_W'(-i_den) : DATA_W'(i_den);
    assign shifted = {r_rem, r_dvd[DVD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_den};
    assign ge      = ~diff[DATA_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= (i_den == '0) ? '0 : DCNT_W'(DVD_W);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_dvd   <= {num_mag, {FRAC_W{1'b0}}};
            r_den   <= den_mag;
            r_neg   <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
            r_dz    <= (i_den == '0);
            r_nneg  <= i_num[DATA_W-1];
            r_nzero <= (i_num == '0);
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], ge};
        end
    end

    assign o_done = r_busy && (r_cnt == '0);

    always_comb begin
        if (r_dz) begin
            o_quo = r_nzero ? '0 : (r_nneg ? VAL_MIN : VAL_MAX);
        end else if (r_neg) begin
            if (r_dvd > {{FRAC_W{1'b0}}, 1'b1, {(DATA_W-1){1'b0}}}) begin
                o_quo = VAL_MIN;
            end else begin
                o_quo = DATA_W'(-r_dvd[DATA_W-1:0]);
            end
        end else if (|r_dvd[DVD_W-1:DATA_W-1]) begin
            o_quo = VAL_MAX;
        end else begin
            o_quo = r_dvd[DATA_W-1:0];
        end
    end

endmodule

// ----- hw/rtl/kalman_position_velocity_filter_unit.sv -----
// Two state position/velocity kalman filter top level: sequencer, state and
// one shared multiplier. Uses kpvf_pkg, kpvf_in_if, kpvf_out_if, kpvf_div.
`timescale 1ns / 1ps
// One item takes thirteen multiplies, each a multiply state (operand
// select and product register) and a write-back state (shift, clamp and
// accumulate), on one shared 33x33 multiplier, a sums state, and two gain
// divisions on the bit-serial divider. The input is ready only while the
// block is idle; a result waits in the output register while the next
// item is taken. Writes to the initial position or speed register load
// that estimate and reset the covariance to identity.
module kalman_position_velocity_filter_unit import kpvf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_W-1:0]     i_cfg_data,
    kpvf_in_if.sink               i_in,
    kpvf_out_if.source            o_out
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_WB    = 3'd2;
    localparam logic [2:0] ST_SUMS  = 3'd3;
    localparam logic [2:0] ST_DIV0  = 3'd4;
    localparam logic [2:0] ST_WAIT0 = 3'd5;
    localparam logic [2:0] ST_WAIT1 = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    localparam logic [3:0] M_B0   = 4'd0;
    localparam logic [3:0] M_X0A  = 4'd1;
    localparam logic [3:0] M_X0B  = 4'd2;
    localparam logic [3:0] M_X1   = 4'd3;
    localparam logic [3:0] M_T00  = 4'd4;
    localparam logic [3:0] M_T01  = 4'd5;
    localparam logic [3:0] M_N00  = 4'd6;
    localparam logic [3:0] M_X0C  = 4'd7;
    localparam logic [3:0] M_X1C  = 4'd8;
    localparam logic [3:0] M_P10  = 4'd9;
    localparam logic [3:0] M_P00  = 4'd10;
    localparam logic [3:0] M_P11  = 4'd11;
    localparam logic [3:0] M_P01  = 4'd12;

    logic [2:0] r_state, n_state;
    logic [3:0] r_step;

    logic [DT_W-1:0]    r_dt;
    logic [NOISE_W-1:0] r_q;
    logic [NOISE_W-1:0] r_r;

    logic signed [DATA_W-1:0] r_x0, r_x1, r_p00, r_p01, r_p10, r_p11;
    logic signed [DATA_W-1:0] r_a, r_z, r_b0, r_s, r_e, r_k0, r_k1;
    logic signed [SUM_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] r_prod;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_pos, r_out_spd;

    logic signed [OP_W-1:0]   op_a, op_b;
    logic signed [DATA_W-1:0] m;
    logic signed [SUM_W-1:0]  m_x, q_x;
    logic signed [DATA_W-1:0] div_num;
    logic                     div_start, div_done;
    logic signed [DATA_W-1:0] div_quo;
    logic                     in_acc, out_load;

    assign in_acc   = i_in.valid && (r_state == ST_IDLE);
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);
    assign i_in.ready = (r_state == ST_IDLE);

    // operand select for the shared multiplier
    always_comb begin
        op_a = OP_W'(signed'({1'b0, r_dt}));
        op_b = OP_W'(r_x1);
        case (r_step)
            M_B0:  op_b = OP_W'(signed'({1'b0, r_dt}));
            M_X0A: op_b = OP_W'(r_x1);
            M_X0B: begin
                op_a = OP_W'(r_b0);
                op_b = OP_W'(r_a);
            end
            M_X1:  op_b = OP_W'(r_a);
            M_T00: op_b = OP_W'(r_p10);
            M_T01: op_b = OP_W'(r_p11);
            M_N00: op_b = OP_W'(r_p01);
            M_X0C: begin
                op_a = OP_W'(r_k0);
                op_b = OP_W'(r_e);
            end
            M_X1C: begin
                op_a = OP_W'(r_k1);
                op_b = OP_W'(r_e);
            end
            M_P10: begin
                op_a = OP_W'(r_k1);
                op_b = OP_W'(r_p00);
            end
            M_P00: begin
                op_a = OP_W'(r_k0);
                op_b = OP_W'(r_p00);
            end
            M_P11: begin
                op_a = OP_W'(r_k1);
                op_b = OP_W'(r_p01);
            end
            M_P01: begin
                op_a = OP_W'(r_k0);
                op_b = OP_W'(r_p01);
            end
            default: ;
        endcase
    end

    assign m   = sat_prod(r_prod);
    assign m_x = SUM_W'(m);
    assign q_x = SUM_W'(signed'({1'b0, r_q}));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in.valid) n_state = ST_MUL;
            ST_MUL:   n_state = ST_WB;
            ST_WB: begin
                if (r_step == M_N00) begin
                    n_state = ST_SUMS;
                end else if (r_step == M_P01) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_SUMS:  n_state = ST_DIV0;
            ST_DIV0:  n_state = ST_WAIT0;
            ST_WAIT0: if (div_done) n_state = ST_WAIT1;
            ST_WAIT1: if (div_done) n_state = ST_MUL;
            ST_DONE:  if (out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // second division starts the cycle the first one reports
    assign div_start = (r_state == ST_DIV0) || (r_state == ST_WAIT0 && div_done);
    assign div_num   = (r_state == ST_DIV0) ? r_p00 : r_p10;

    kpvf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_s),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= M_B0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_step <= M_B0;
            end else if (r_state == ST_WB && r_step != M_N00 && r_step != M_P01) begin
                r_step <= r_step + 1'b1;
            end else if (r_state == ST_WAIT1 && div_done) begin
                r_step <= M_X0C;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pos <= r_x0;
            r_out_spd <= r_x1;
        end
        if (in_acc) begin
            r_a <= i_in.acceleration;
            r_z <= i_in.measured_position;
        end
        if (r_state == ST_MUL) begin
            r_prod <= op_a * op_b;
        end
        if (r_state == ST_SUMS) begin
            r_s <= sat_sum(SUM_W'(r_p00) + SUM_W'(signed'({1'b0, r_r})));
            r_e <= sat_sum(SUM_W'(r_z) - SUM_W'(r_x0));
        end
        if (r_state == ST_WAIT0 && div_done) r_k0 <= div_quo;
        if (r_state == ST_WAIT1 && div_done) r_k1 <= div_quo;
        if (r_state == ST_WB && r_step == M_B0) r_b0 <= m >>> 1;
        if (r_state == ST_WB && r_step == M_X0A) r_acc <= SUM_W'(r_x0) + m_x;
    end

    // configuration and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt  <= RST_TIME_STEP;
            r_q   <= RST_PROC_NOISE;
            r_r   <= RST_MEAS_NOISE;
            r_x0  <= '0;
            r_x1  <= '0;
            r_p00 <= VAL_ONE;
            r_p01 <= '0;
            r_p10 <= '0;
            r_p11 <= VAL_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIME_STEP:  r_dt <= i_cfg_data[DT_W-1:0];
                CFG_PROC_NOISE: r_q  <= i_cfg_data[NOISE_W-1:0];
                CFG_MEAS_NOISE: r_r  <= i_cfg_data[NOISE_W-1:0];
                CFG_INIT_POS, CFG_INIT_SPEED: begin
                    if (i_cfg_idx == CFG_INIT_POS) begin
                        r_x0 <= i_cfg_data;
                    end else begin
                        r_x1 <= i_cfg_data;
                    end
                    r_p00 <= VAL_ONE;
                    r_p01 <= '0;
                    r_p10 <= '0;
                    r_p11 <= VAL_ONE;
                end
                default: ;
            endcase
        end else if (r_state == ST_WB) begin
            case (r_step)
                M_X0B: r_x0 <= sat_sum(r_acc + m_x);
                M_X1:  r_x1 <= sat_sum(SUM_W'(r_x1) + m_x);
                M_T00: r_p00 <= sat_sum(SUM_W'(r_p00) + m_x);
                M_T01: begin
                    r_p01 <= sat_sum(SUM_W'(r_p01) + m_x);
                    r_p10 <= sat_sum(SUM_W'(r_p10) + m_x);
                end
                M_N00: begin
                    r_p00 <= sat_sum(SUM_W'(r_p00) + m_x + q_x);
                    r_p11 <= sat_sum(SUM_W'(r_p11) + q_x);
                end
                M_X0C: r_x0  <= sat_sum(SUM_W'(r_x0) + m_x);
                M_X1C: r_x1  <= sat_sum(SUM_W'(r_x1) + m_x);
                M_P10: r_p10 <= sat_sum(SUM_W'(r_p10) - m_x);
                M_P00: r_p00 <= sat_sum(SUM_W'(r_p00) - m_x);
                M_P11: r_p11 <= sat_sum(SUM_W'(r_p11) - m_x);
                M_P01: r_p01 <= sat_sum(SUM_W'(r_p01) - m_x);
                default: ;
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.est_position = r_out_pos;
    assign o_out.est_speed    = r_out_spd;

endmodule

// ----- hw/rtl/kpvf_checker.sv -----
// kpvf_assertions: port-level assertions for the kalman filter top level,
// bound to kalman_position_velocity_filter_unit. Uses kpvf_pkg.
`timescale 1ns / 1ps
module kpvf_assertions import kpvf_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    // a held result is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // an accepted item keeps the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    // a result never appears on the cycle after an item is taken
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result item too early");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind kalman_position_velocity_filter_unit kpvf_assertions u_kpvf_assertions (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);
